[hw/rtl/lcc_pkg.sv]
// ----------------------------------------------------------------------------
// Card number classifier package
// Widths, constants, class codes and state types shared by the classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int CARD_BITS  = 54;
   localparam int MAX_DIGITS = 16;
   localparam int BCD_DIGITS = 17;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int CNT_W      = 6;
   localparam int DC_W       = 5;
   localparam int CLASS_W    = 2;

   localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CARD_BITS - 1);
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(BCD_DIGITS - 1);
   localparam logic [DC_W-1:0]  DC_SATURATED = DC_W'(MAX_DIGITS + 1);
   localparam logic [DC_W-1:0]  DC_LIMIT     = DC_W'(MAX_DIGITS);

   localparam logic [DC_W-1:0] LEN_THIRTEEN = 5'd13;
   localparam logic [DC_W-1:0] LEN_FIFTEEN  = 5'd15;
   localparam logic [DC_W-1:0] LEN_SIXTEEN  = 5'd16;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_INVALID = 2'd0,
      CLASS_THREE   = 2'd1,
      CLASS_FIVE    = 2'd2,
      CLASS_FOUR    = 2'd3
   } card_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/lcc_if.sv]
// ----------------------------------------------------------------------------
// Card number classifier channels
// Valid/ready channels for the card number request and the class response.
// ----------------------------------------------------------------------------
interface lcc_req_if;
   logic                           valid;
   logic                           ready;
   logic [lcc_pkg::CARD_BITS-1:0]  card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

interface lcc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lcc_pkg::CLASS_W-1:0]    card_class;
   logic                           luhn_ok;
   logic [lcc_pkg::DC_W-1:0]       digit_count;

   modport source (output valid, output card_class, output luhn_ok,
                   output digit_count, input ready);
   modport sink   (input valid, input card_class, input luhn_ok,
                   input digit_count, output ready);
endinterface

[hw/rtl/luhn_card_number_classifier_top.sv]
// ----------------------------------------------------------------------------
// Card number classifier
// Converts a binary card number to decimal, forms the Luhn sum and classifies
// the issuer from the length and the two leading digits when the Luhn sum passes.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_ch    in         card_number (54 bits)
//  rsp_ch    out        card_class (2), luhn_ok (1), digit_count (5)
//
//  A request is accepted, then goes through the shift-and-add-3 binary to
//  decimal conversion (one input bit per cycle), the digit scan (one digit
//  per cycle through the Luhn adder) and a last step that posts the result.
//  The response sits in an output register; a new request is accepted while
//  it waits. A stalled response holds the block in its last step only.
//  Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier_top (
   input  logic         clock,
   input  logic         reset,
   lcc_req_if.sink      req_ch,
   lcc_rsp_if.source    rsp_ch
);

   lcc_pkg::state_type                 state_ff, state_in;
   logic [lcc_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [lcc_pkg::CARD_BITS-1:0]      bin_ff, bin_in;
   logic [lcc_pkg::BCD_W-1:0]          bcd_ff, bcd_in;
   logic [3:0]                         sum_ff, sum_in;
   logic [lcc_pkg::DC_W-1:0]           count_ff, count_in;
   logic [3:0]                         lead_ff, lead_in;
   logic [3:0]                         next_ff, next_in;
   logic [3:0]                         prev_ff, prev_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lcc_pkg::CLASS_W-1:0]        class_ff, class_in;
   logic                               ok_ff, ok_in;
   logic [lcc_pkg::DC_W-1:0]           dc_ff, dc_in;

   logic                               req_take;
   logic                               rsp_free;
   logic [lcc_pkg::BCD_W-1:0]          bcd_adj;
   logic [3:0]                         digit;
   logic [4:0]                         dbl;
   logic [3:0]                         term;
   logic [4:0]                         sum_raw;
   logic                               luhn_zero;
   lcc_pkg::card_class_type            cls;

   assign req_ch.ready = (state_ff == lcc_pkg::ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.card_class  = class_ff;
   assign rsp_ch.luhn_ok     = ok_ff;
   assign rsp_ch.digit_count = dc_ff;

   // Add 3 to every decimal digit that is 5 or more before the shift.
   always_comb begin
      logic [3:0] nib;
      for (int i = 0; i < lcc_pkg::BCD_DIGITS; i++) begin
         nib = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   // Luhn term of the digit in the low nibble; odd counter values are even
   // positions from the right.
   assign digit   = bcd_ff[3:0];
   assign dbl     = {digit, 1'b0};
   assign term    = cnt_ff[0] ? ((dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0]) : digit;
   assign sum_raw = {1'b0, sum_ff} + {1'b0, term};

   assign luhn_zero = (sum_ff == 4'd0);

   always_comb begin
      cls = lcc_pkg::CLASS_INVALID;
      if (luhn_zero) begin
         case (count_ff)
            lcc_pkg::LEN_SIXTEEN: begin
               if (lead_ff == 4'd5 && next_ff >= 4'd1 && next_ff <= 4'd5) begin
                  cls = lcc_pkg::CLASS_FIVE;
               end else if (lead_ff == 4'd4) begin
                  cls = lcc_pkg::CLASS_FOUR;
               end
            end
            lcc_pkg::LEN_FIFTEEN: begin
               if (lead_ff == 4'd3 && (next_ff == 4'd4 || next_ff == 4'd7)) begin
                  cls = lcc_pkg::CLASS_THREE;
               end
            end
            lcc_pkg::LEN_THIRTEEN: begin
               if (lead_ff == 4'd4) begin
                  cls = lcc_pkg::CLASS_FOUR;
               end
            end
            default: cls = lcc_pkg::CLASS_INVALID;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      sum_ff   <= sum_in;
      count_ff <= count_in;
      lead_ff  <= lead_in;
      next_ff  <= next_in;
      prev_ff  <= prev_in;
      class_ff <= class_in;
      ok_ff    <= ok_in;
      dc_ff    <= dc_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      lead_in      = lead_ff;
      next_in      = next_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      class_in     = class_ff;
      ok_in        = ok_ff;
      dc_in        = dc_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lcc_pkg::ST_IDLE: begin
            if (req_take) begin
               bin_in   = req_ch.card_number;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = lcc_pkg::ST_CONVERT;
            end
         end
         lcc_pkg::ST_CONVERT: begin
            bcd_in = {bcd_adj[lcc_pkg::BCD_W-2:0], bin_ff[lcc_pkg::CARD_BITS-1]};
            bin_in = {bin_ff[lcc_pkg::CARD_BITS-2:0], 1'b0};
            if (cnt_ff == lcc_pkg::CONV_LAST) begin
               cnt_in   = '0;
               sum_in   = '0;
               count_in = '0;
               lead_in  = '0;
               next_in  = '0;
               prev_in  = '0;
               state_in = lcc_pkg::ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lcc_pkg::ST_SCAN: begin
            sum_in  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
            prev_in = digit;
            if (digit != 4'd0) begin
               count_in = cnt_ff[lcc_pkg::DC_W-1:0] + 1'b1;
               lead_in  = digit;
               next_in  = prev_ff;
            end
            bcd_in = {4'd0, bcd_ff[lcc_pkg::BCD_W-1:4]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lcc_pkg::SCAN_LAST) begin
               state_in = lcc_pkg::ST_FINISH;
            end
         end
         lcc_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               class_in     = cls;
               ok_in        = luhn_zero;
               dc_in        = (count_ff > lcc_pkg::DC_LIMIT) ? lcc_pkg::DC_SATURATED
                                                              : count_ff;
               state_in     = lcc_pkg::ST_IDLE;
            end
         end
         default: state_in = lcc_pkg::ST_IDLE;
      endcase
   end

   // A request starts the conversion in the very next cycle.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == lcc_pkg::ST_CONVERT && cnt_ff == '0))
      else $error("conversion did not start after request");

   // A valid issuer class always comes with a passing checksum.
   a_class_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && class_ff != lcc_pkg::CLASS_INVALID) |-> ok_ff)
      else $error("issuer class without passing checksum");

   // A valid issuer class only for lengths 13, 15 or 16.
   a_class_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && class_ff != lcc_pkg::CLASS_INVALID) |->
         (dc_ff == lcc_pkg::LEN_THIRTEEN || dc_ff == lcc_pkg::LEN_FIFTEEN ||
          dc_ff == lcc_pkg::LEN_SIXTEEN))
      else $error("issuer class with wrong length");

   // The reported digit count never passes its saturation value.
   a_dc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dc_ff <= lcc_pkg::DC_SATURATED))
      else $error("digit count out of range");

endmodule
